>>> rtl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// Types, widths and codes shared by the centroid steering pipeline.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int LANES      = 4;
    localparam int ID_W       = 9;
    localparam int BOX_W      = 12;
    localparam int HOM_W      = 48;
    localparam int TID_W      = 8;
    localparam int CX_W       = 12;
    localparam int GAIN_W     = 20;
    localparam int SPD_W      = 15;
    localparam int TURN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Products are split at this bit so that no multiplier exceeds 32 bits.
    localparam int LO_W    = 32;
    localparam int LO_PP_W = LO_W + BOX_W;
    localparam int HI_W    = HOM_W - LO_W + BOX_W + 1;
    localparam int PROD_W  = HI_W + LO_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = SUM_W;

    // Division: 30 integer bits and 8 fraction bits of quotient.
    localparam int XFRAC    = 8;
    localparam int QINT     = 30;
    localparam int Q_W      = QINT + XFRAC;
    localparam int REM_W    = MAG_W + XFRAC;
    localparam int CMP_W    = MAG_W + Q_W;
    localparam int SAT_W    = MAG_W + QINT;
    localparam int XVAL_W   = Q_W + 1;

    // Averaging and steering.
    localparam int AVG_SH   = XFRAC + 2;
    localparam int XSUM_W   = XVAL_W + 2;
    localparam int AVG_W    = XSUM_W - AVG_SH;
    localparam int OFS_W    = AVG_W + 1;
    localparam int ANG_W    = GAIN_W + 1 + OFS_W;
    localparam int ANG_SH   = 10;
    localparam int M14_W    = ANG_W - ANG_SH;
    localparam logic [XSUM_W-1:0] AVG_BIAS = XSUM_W'((1 << AVG_SH) - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd4;

    localparam logic [TID_W-1:0]  RST_TARGET_ID = 8'd6;
    localparam logic [CX_W-1:0]   RST_CENTER_X  = 12'd320;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 20'd33554;
    localparam logic [SPD_W-1:0]  RST_MIN_SPEED = 15'd2458;
    localparam logic [SPD_W-1:0]  RST_MAX_SPEED = 15'd8192;

    typedef struct packed {
        logic signed [ID_W-1:0]  object_id;
        logic [BOX_W-1:0]        box_width;
        logic [BOX_W-1:0]        box_height;
        logic signed [HOM_W-1:0] hom_a;
        logic signed [HOM_W-1:0] hom_b;
        logic signed [HOM_W-1:0] hom_c;
        logic signed [HOM_W-1:0] hom_d;
        logic signed [HOM_W-1:0] hom_e;
        logic signed [HOM_W-1:0] hom_f;
        logic signed [HOM_W-1:0] hom_g;
        logic signed [HOM_W-1:0] hom_h;
        logic signed [HOM_W-1:0] hom_i;
    } t_in_item;

    typedef struct packed {
        logic signed [TURN_W-1:0] turn_rate;
        logic                     tracking;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic match;
    } t_tag;

    typedef struct packed {
        logic [TID_W-1:0]  target_id;
        logic [CX_W-1:0]   center_x;
        logic [GAIN_W-1:0] gain;
        logic [SPD_W-1:0]  min_speed;
        logic [SPD_W-1:0]  max_speed;
    } t_cfg;

endpackage

>>> rtl/hcs_front.sv
// ----------------------------------------------------------------------------
// hcs_front
// Id match, split products and corner numerators and denominators.
// ----------------------------------------------------------------------------
module hcs_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  hcs_pkg::t_in_item                  i_item,
    input  logic [hcs_pkg::TID_W-1:0]          i_target_id,
    output hcs_pkg::t_tag                      o_tag,
    output logic signed [hcs_pkg::SUM_W-1:0]   o_num [hcs_pkg::LANES],
    output logic signed [hcs_pkg::SUM_W-1:0]   o_den [hcs_pkg::LANES]
);
    import hcs_pkg::*;

    t_tag                     r1_tag, r2_tag, r3_tag;
    logic [LO_PP_W-1:0]       r1_lo [LANES];
    logic signed [HI_W-1:0]   r1_hi [LANES];
    logic signed [HOM_W-1:0]  r1_g, r1_i, r2_g, r2_i;
    logic signed [PROD_W-1:0] r2_p [LANES];
    logic signed [SUM_W-1:0]  r3_num [LANES];
    logic signed [SUM_W-1:0]  r3_den [LANES];

    logic signed [HOM_W-1:0]  mc [LANES];
    logic [BOX_W-1:0]         ml [LANES];
    logic signed [SUM_W-1:0]  sg, si, s0, s1, s2, s3;

    // Lanes: a*w, d*h, c*w, f*h.
    always_comb begin
        mc[0] = i_item.hom_a;
        mc[1] = i_item.hom_d;
        mc[2] = i_item.hom_c;
        mc[3] = i_item.hom_f;
        ml[0] = i_item.box_width;
        ml[1] = i_item.box_height;
        ml[2] = i_item.box_width;
        ml[3] = i_item.box_height;
    end

    always_comb begin
        sg = SUM_W'(r2_g);
        si = SUM_W'(r2_i);
        s0 = SUM_W'(r2_p[0]);
        s1 = SUM_W'(r2_p[1]);
        s2 = SUM_W'(r2_p[2]);
        s3 = SUM_W'(r2_p[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
        end else if (i_en) begin
            r1_tag.valid <= i_valid;
            r1_tag.match <= (i_item.object_id == $signed({1'b0, i_target_id}));
            r2_tag       <= r1_tag;
            r3_tag       <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r1_lo[l] <= LO_PP_W'(mc[l][LO_W-1:0]) * LO_PP_W'(ml[l]);
                r1_hi[l] <= HI_W'($signed(mc[l][HOM_W-1:LO_W]))
                            * HI_W'($signed({1'b0, ml[l]}));
                r2_p[l]  <= $signed({r1_hi[l], {LO_W{1'b0}}})
                            + $signed(PROD_W'(r1_lo[l]));
            end
            r1_g      <= i_item.hom_g;
            r1_i      <= i_item.hom_i;
            r2_g      <= r1_g;
            r2_i      <= r1_i;
            r3_num[0] <= sg;
            r3_num[1] <= s0 + sg;
            r3_num[2] <= s1 + sg;
            r3_num[3] <= s0 + s1 + sg;
            r3_den[0] <= si;
            r3_den[1] <= s2 + si;
            r3_den[2] <= s3 + si;
            r3_den[3] <= s2 + s3 + si;
        end
    end

    assign o_tag = r3_tag;
    assign o_num = r3_num;
    assign o_den = r3_den;

endmodule

>>> rtl/hcs_div.sv
// ----------------------------------------------------------------------------
// hcs_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hcs_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  hcs_pkg::t_tag                      i_tag,
    input  logic signed [hcs_pkg::SUM_W-1:0]   i_num [hcs_pkg::LANES],
    input  logic signed [hcs_pkg::SUM_W-1:0]   i_den [hcs_pkg::LANES],
    output hcs_pkg::t_tag                      o_tag,
    output logic signed [hcs_pkg::XVAL_W-1:0]  o_x [hcs_pkg::LANES]
);
    import hcs_pkg::*;

    t_tag               ra_tag;
    logic [MAG_W-1:0]   ra_n [LANES];
    logic [MAG_W-1:0]   ra_d [LANES];
    logic               ra_neg [LANES];
    logic               ra_zero [LANES];

    t_tag               r_tag [Q_W+1];
    logic [REM_W-1:0]   r_rem [Q_W+1][LANES];
    logic [MAG_W-1:0]   r_d [Q_W+1][LANES];
    logic [Q_W-1:0]     r_q [Q_W+1][LANES];
    logic               r_sat [Q_W+1][LANES];
    logic               r_neg [Q_W+1][LANES];
    logic               r_zero [Q_W+1][LANES];

    t_tag                     r_out_tag;
    logic signed [XVAL_W-1:0] r_x [LANES];

    logic [REM_W-1:0]   n_rem [Q_W][LANES];
    logic [Q_W-1:0]     n_q [Q_W][LANES];
    logic [XVAL_W-1:0]  n_val [LANES];

    // Stage s decides quotient bit Q_W-1-s.
    always_comb begin
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rext;
        for (int s = 0; s < Q_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                dsh  = CMP_W'(r_d[s][l]) << (Q_W - 1 - s);
                rext = CMP_W'(r_rem[s][l]);
                if (rext >= dsh) begin
                    n_rem[s][l] = REM_W'(rext - dsh);
                    n_q[s][l]   = r_q[s][l] | (Q_W'(1) << (Q_W - 1 - s));
                end else begin
                    n_rem[s][l] = r_rem[s][l];
                    n_q[s][l]   = r_q[s][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_zero[Q_W][l]) begin
                n_val[l] = '0;
            end else if (r_sat[Q_W][l]) begin
                n_val[l] = XVAL_W'({Q_W{1'b1}});
            end else begin
                n_val[l] = XVAL_W'(r_q[Q_W][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_tag    <= '0;
            r_out_tag <= '0;
            for (int s = 0; s <= Q_W; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            ra_tag   <= i_tag;
            r_tag[0] <= ra_tag;
            for (int s = 0; s < Q_W; s++) begin
                r_tag[s+1] <= r_tag[s];
            end
            r_out_tag <= r_tag[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                ra_n[l]    <= i_num[l][SUM_W-1] ? MAG_W'(-i_num[l]) : MAG_W'(i_num[l]);
                ra_d[l]    <= i_den[l][SUM_W-1] ? MAG_W'(-i_den[l]) : MAG_W'(i_den[l]);
                ra_neg[l]  <= i_num[l][SUM_W-1] ^ i_den[l][SUM_W-1];
                ra_zero[l] <= (i_den[l] == '0);

                r_rem[0][l]  <= {ra_n[l], {XFRAC{1'b0}}};
                r_d[0][l]    <= ra_d[l];
                r_q[0][l]    <= '0;
                r_sat[0][l]  <= SAT_W'(ra_n[l]) >= (SAT_W'(ra_d[l]) << QINT);
                r_neg[0][l]  <= ra_neg[l];
                r_zero[0][l] <= ra_zero[l];

                for (int s = 0; s < Q_W; s++) begin
                    r_rem[s+1][l]  <= n_rem[s][l];
                    r_q[s+1][l]    <= n_q[s][l];
                    r_d[s+1][l]    <= r_d[s][l];
                    r_sat[s+1][l]  <= r_sat[s][l];
                    r_neg[s+1][l]  <= r_neg[s][l];
                    r_zero[s+1][l] <= r_zero[s][l];
                end

                r_x[l] <= r_neg[Q_W][l] ? -$signed(n_val[l]) : $signed(n_val[l]);
            end
        end
    end

    assign o_tag = r_out_tag;
    assign o_x   = r_x;

endmodule

>>> rtl/hcs_post.sv
// ----------------------------------------------------------------------------
// hcs_post
// Corner averaging, gain multiply, deadband and clamp.
// ----------------------------------------------------------------------------
module hcs_post (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  hcs_pkg::t_cfg                      i_cfg,
    input  hcs_pkg::t_tag                      i_tag,
    input  logic signed [hcs_pkg::XVAL_W-1:0]  i_x [hcs_pkg::LANES],
    output logic                               o_valid,
    output hcs_pkg::t_out_item                 o_item
);
    import hcs_pkg::*;

    t_tag                     r1_tag, r2_tag, r3_tag, r4_tag;
    logic signed [XSUM_W-1:0] r1_sum;
    logic signed [OFS_W-1:0]  r2_ofs;
    logic signed [ANG_W-1:0]  r3_ang;
    t_out_item                r4_item;

    logic signed [XSUM_W-1:0] biased;
    logic signed [XSUM_W-1:0] shifted;
    logic [ANG_W-1:0]         ang_mag;
    logic [M14_W-1:0]         m14;
    logic [M14_W-1:0]         lim;
    t_out_item                n4_item;

    always_comb begin
        // Add the bias on negative sums so the shift truncates toward zero.
        biased  = r1_sum + (r1_sum[XSUM_W-1] ? $signed(AVG_BIAS) : $signed(XSUM_W'(0)));
        shifted = biased >>> AVG_SH;
    end

    always_comb begin
        ang_mag = r3_ang[ANG_W-1] ? ANG_W'(-r3_ang) : ANG_W'(r3_ang);
        m14     = M14_W'(ang_mag >> ANG_SH);
        if (m14 < M14_W'(i_cfg.min_speed)) begin
            lim = '0;
        end else if (m14 > M14_W'(i_cfg.max_speed)) begin
            lim = M14_W'(i_cfg.max_speed);
        end else begin
            lim = m14;
        end
        n4_item.tracking  = r3_tag.match;
        if (!r3_tag.match) begin
            n4_item.turn_rate = '0;
        end else if (r3_ang[ANG_W-1]) begin
            n4_item.turn_rate = -$signed(TURN_W'(lim));
        end else begin
            n4_item.turn_rate = $signed(TURN_W'(lim));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sum  <= XSUM_W'(i_x[0]) + XSUM_W'(i_x[1])
                       + XSUM_W'(i_x[2]) + XSUM_W'(i_x[3]);
            r2_ofs  <= $signed(OFS_W'(i_cfg.center_x)) - OFS_W'(shifted);
            r3_ang  <= ANG_W'($signed({1'b0, i_cfg.gain})) * ANG_W'(r2_ofs);
            r4_item <= n4_item;
        end
    end

    assign o_valid = r4_tag.valid;
    assign o_item  = r4_item;

endmodule

>>> rtl/homography_centroid_steering.sv
// ----------------------------------------------------------------------------
// homography_centroid_steering
// Projects a matched object's box through its homography and steers to it.
// ----------------------------------------------------------------------------
// The block takes one detection per clock cycle unless stalled and returns
// one result for every detection, in order: 3 stages form the corner
// products and sums, 41 stages run the four-lane divider (one quotient bit
// per stage over 38 bits, plus setup and sign stages), and 4 stages do the
// averaging, the gain multiply and the deadband and clamp. Throughput is one
// transfer per cycle while the output is not stalled. When a finished result
// is held back by the output stall, the whole pipeline freezes and the input
// stall rises in the same cycle, so nothing is dropped or repeated. A result
// whose id does not match target_id carries tracking 0 and turn rate 0.
// Configuration writes are registered and should be made while idle.
// ----------------------------------------------------------------------------
module homography_centroid_steering (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  hcs_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output hcs_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [hcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hcs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hcs_pkg::*;

    t_cfg                     r_cfg;
    logic                     en;
    t_tag                     f_tag, d_tag;
    logic signed [SUM_W-1:0]  f_num [LANES];
    logic signed [SUM_W-1:0]  f_den [LANES];
    logic signed [XVAL_W-1:0] d_x [LANES];

    // Every stage advances together unless a result waits on a stalled output.
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_id <= RST_TARGET_ID;
            r_cfg.center_x  <= RST_CENTER_X;
            r_cfg.gain      <= RST_GAIN;
            r_cfg.min_speed <= RST_MIN_SPEED;
            r_cfg.max_speed <= RST_MAX_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_ID: r_cfg.target_id <= i_cfg_data[TID_W-1:0];
                CFG_CENTER_X:  r_cfg.center_x  <= i_cfg_data[CX_W-1:0];
                CFG_GAIN:      r_cfg.gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_MIN_SPEED: r_cfg.min_speed <= i_cfg_data[SPD_W-1:0];
                CFG_MAX_SPEED: r_cfg.max_speed <= i_cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    hcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_item      (i_in_item),
        .i_target_id (r_cfg.target_id),
        .o_tag       (f_tag),
        .o_num       (f_num),
        .o_den       (f_den)
    );

    hcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (f_tag),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_tag   (d_tag),
        .o_x     (d_x)
    );

    hcs_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_tag   (d_tag),
        .i_x     (d_x),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    // A result that is not tracking never commands a turn.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.tracking) |-> (o_out_item.turn_rate == '0))
        else $error("turn rate set on a result that is not tracking");

    // The input is held off only while a finished result waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // A waiting result is still there in the next cycle.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result was dropped");

endmodule

>>> dv/hcs_checker.sv
// ----------------------------------------------------------------------------
// hcs_checker
// Watches both channels of the centroid steering block, predicts every result
// from the accepted detections and the register file, and compares in order.
// ----------------------------------------------------------------------------
module hcs_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  hcs_pkg::t_in_item               i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  hcs_pkg::t_out_item              i_out_item,
    input  logic                            i_cfg_we,
    input  logic [hcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hcs_pkg::*;

    t_cfg      regs;
    t_out_item steer_queue[$];
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = steer_queue.size();

    // Quotient of num/den truncated toward zero to eight fraction bits, with
    // the integer part saturated just below 2^30 pixels.
    function automatic longint project_x(input logic signed [127:0] num,
                                         input logic signed [127:0] den);
        logic [127:0] n, d, qi, r, q;
        if (den == 0) return 0;
        n  = num < 0 ? -num : num;
        d  = den < 0 ? -den : den;
        qi = n / d;
        if (qi >= (128'd1 << 30)) begin
            q = (128'd1 << 38) - 1;
        end else begin
            r = n % d;
            q = (qi << 8) | ((r << 8) / d);
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_out_item steer_for(input t_in_item it, input t_cfg c);
        t_out_item             res;
        logic signed [127:0]   hx[3], hz[3], num, den;
        longint                sum, avg, offset, ang, m14;
        int                    xs, ys;
        res = '0;
        if (it.object_id != $signed({1'b0, c.target_id})) return res;
        hx = '{it.hom_a, it.hom_d, it.hom_g};
        hz = '{it.hom_c, it.hom_f, it.hom_i};
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            xs  = (k % 2) ? it.box_width : 0;
            ys  = (k / 2) ? it.box_height : 0;
            num = hx[0] * xs + hx[1] * ys + hx[2];
            den = hz[0] * xs + hz[1] * ys + hz[2];
            sum += project_x(num, den);
        end
        avg    = sum / 1024;
        offset = longint'(c.center_x) - avg;
        ang    = longint'(c.gain) * offset;
        m14    = (ang < 0 ? -ang : ang) >>> 10;
        if (m14 < c.min_speed) m14 = 0;
        else if (m14 > c.max_speed) m14 = c.max_speed;
        res.turn_rate = ang < 0 ? -m14 : m14;
        res.tracking  = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            regs  <= '{RST_TARGET_ID, RST_CENTER_X, RST_GAIN, RST_MIN_SPEED, RST_MAX_SPEED};
            fails <= 0;
            steer_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_ID: regs.target_id <= i_cfg_data[TID_W-1:0];
                    CFG_CENTER_X:  regs.center_x  <= i_cfg_data[CX_W-1:0];
                    CFG_GAIN:      regs.gain      <= i_cfg_data[GAIN_W-1:0];
                    CFG_MIN_SPEED: regs.min_speed <= i_cfg_data[SPD_W-1:0];
                    CFG_MAX_SPEED: regs.max_speed <= i_cfg_data[SPD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                steer_queue = {steer_queue, steer_for(i_in_item, regs)};
            if (i_out_valid && !i_out_stall) begin
                if (steer_queue.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    want = steer_queue.pop_front();
                    if (want.turn_rate !== i_out_item.turn_rate) begin
                        $error("turn_rate expected %0d actual %0d",
                               want.turn_rate, i_out_item.turn_rate);
                        errs++;
                    end
                    if (want.tracking !== i_out_item.tracking) begin
                        $error("tracking expected %0d actual %0d",
                               want.tracking, i_out_item.tracking);
                        errs++;
                    end
                end
            end
            fails <= fails + errs;
        end
    end

endmodule

>>> dv/homography_centroid_steering_test.sv
// ----------------------------------------------------------------------------
// homography_centroid_steering_test
// Drives detections and register settings into the steering block with random
// idling and long output hold-offs; the checker predicts and compares.
// ----------------------------------------------------------------------------
module homography_centroid_steering_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hcs_pkg::*;

    // An index that selects no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                  clk, rst_n;
    logic                  in_valid, in_stall, out_valid, out_stall;
    t_in_item              in_item;
    t_out_item             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count, pending;
    // Idling percentage on each side; zero during the quiet stretch.
    int                    send_idle_pct = 8;
    int                    recv_idle_pct = 8;
    bit                    hold_off;
    logic [TID_W-1:0]      cur_target = RST_TARGET_ID;

    homography_centroid_steering DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    hcs_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, or solidly while a hold-off is requested.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [HOM_W-1:0] rand_hom();
        logic [HOM_W-1:0] v;
        v = HOM_W'({$urandom, $urandom});
        case ($urandom_range(5))
            0: return v;
            1: return {{16{v[47]}}, v[31:0]};
            2: return {{24{v[47]}}, v[23:0]};
            3: return $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            4: return '0;
            default: return {{8{v[47]}}, v[39:0]};
        endcase
    endfunction

    // Mostly a plausible homography: near identity scale with a modest shift; else random.
    function automatic t_in_item make_item(input bit match);
        t_in_item it;
        it.object_id  = match ? $signed({1'b0, cur_target})
                              : ID_W'($urandom_range(511));
        it.box_width  = $urandom_range(3) == 0 ? BOX_W'($urandom)
                                               : BOX_W'($urandom_range(200));
        it.box_height = $urandom_range(3) == 0 ? BOX_W'($urandom)
                                               : BOX_W'($urandom_range(200));
        if ($urandom_range(3) == 0) begin
            it.hom_a = rand_hom(); it.hom_b = rand_hom(); it.hom_c = rand_hom();
            it.hom_d = rand_hom(); it.hom_e = rand_hom(); it.hom_f = rand_hom();
            it.hom_g = rand_hom(); it.hom_h = rand_hom(); it.hom_i = rand_hom();
        end else begin
            it.hom_a = (48'sd1 <<< 32)
                       + ($signed(48'($urandom_range(65535)) - 32768) <<< 12);
            it.hom_b = rand_hom();
            it.hom_c = $signed(48'($urandom_range(4095)) - 2048) <<< 8;
            it.hom_d = $signed(48'($urandom_range(65535)) - 32768) <<< 12;
            it.hom_e = rand_hom();
            it.hom_f = $signed(48'($urandom_range(4095)) - 2048) <<< 8;
            it.hom_g = $signed(48'($urandom_range(1023))) <<< 32;
            it.hom_h = rand_hom();
            it.hom_i = 48'sd1 <<< 32;
        end
        return it;
    endfunction

    task automatic send(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_TARGET_ID) cur_target = val[TID_W-1:0];
    endtask

    initial begin
        t_in_item it;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        hold_off = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, wrong id, extremes of box and entries,
        // a zero denominator, a huge projection, deadband and clamp.
        it = '0; it.object_id = -9'sd1; send(it);
        it.object_id = 9'sd255; send(it);
        it.object_id = 9'sd6; send(it);                    // zero denominator everywhere
        it.box_width = '1; it.box_height = '1;
        it.hom_a = 48'h7FFF_FFFF_FFFF; it.hom_d = 48'h7FFF_FFFF_FFFF;
        it.hom_g = 48'h7FFF_FFFF_FFFF; it.hom_i = 48'sd1; send(it);   // saturation
        it.hom_a = 48'h8000_0000_0000; it.hom_d = 48'h8000_0000_0000;
        it.hom_g = 48'h8000_0000_0000; it.hom_c = 48'h8000_0000_0000;
        it.hom_f = 48'h8000_0000_0000; it.hom_i = 48'h8000_0000_0000;
        it.hom_b = '1; it.hom_e = '1; it.hom_h = '1; send(it);
        it = '0; it.object_id = 9'sd6; it.hom_i = 48'sd1 <<< 32;
        it.hom_g = 48'sd320 <<< 32; send(it);               // dead center, deadband
        it.hom_g = 48'sd321 <<< 32; send(it);               // small offset, deadband
        it.hom_g = 48'sd4000 <<< 32; send(it);              // clamp negative
        it.hom_g = -(48'sd4000 <<< 32); send(it);           // clamp positive
        it.hom_c = -(48'sd1 <<< 32); it.box_width = 12'd1;
        it.hom_a = 48'sd5 <<< 32; send(it);                 // two corners divide by zero
        for (int k = 0; k < 8; k++) send(make_item(1'b1));
        drain();

        // Register phases, extremes included; max below min once.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_TARGET_ID, 20'd0);   write_reg(CFG_CENTER_X, 20'd0);
                    write_reg(CFG_GAIN, 20'd0);        write_reg(CFG_MIN_SPEED, 20'd0);
                    write_reg(CFG_MAX_SPEED, 20'd0);
                end
                1: begin
                    write_reg(CFG_TARGET_ID, 20'd255); write_reg(CFG_CENTER_X, 20'd4095);
                    write_reg(CFG_GAIN, 20'hFFFFF);    write_reg(CFG_MIN_SPEED, 20'h7FFF);
                    write_reg(CFG_MAX_SPEED, 20'h7FFF);
                end
                2: begin
                    write_reg(CFG_MIN_SPEED, 20'd9000); write_reg(CFG_MAX_SPEED, 20'd3000);
                    write_reg(CFG_GAIN, 20'd33554);
                end
                3: write_reg(CFG_NO_REG, 20'hFFFFF);  // unused index, no effect
                default: begin
                    write_reg(CFG_TARGET_ID, CFG_DATA_W'($urandom_range(255)));
                    write_reg(CFG_CENTER_X, CFG_DATA_W'($urandom_range(4095)));
                    write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(20'hFFFFF)));
                    write_reg(CFG_MIN_SPEED, CFG_DATA_W'($urandom_range(4000)));
                    write_reg(CFG_MAX_SPEED, CFG_DATA_W'($urandom_range(4000, 32767)));
                end
            endcase
            // One quiet stretch with no idling on either side.
            send_idle_pct = (phase == 5) ? 0 : 8;
            recv_idle_pct = (phase == 5) ? 0 : 8;
            for (int n = 0; n < 200; n++) begin
                if (phase == 6 && n == 20) begin
                    // The receiver holds off long enough to fill the pipeline
                    // while the sender keeps offering transfers.
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (150) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send(make_item($urandom_range(99) < 75));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
